// ----- src/sbio_pkg.sv -----
// shared types, constants and helpers for the board io port decoder
package sbio_pkg;

    localparam int RAM_DEPTH = 3072;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // port codes
    localparam logic [3:0] PORT_A = 4'd0;
    localparam logic [3:0] PORT_B = 4'd1;
    localparam logic [3:0] PORT_C = 4'd2;
    localparam logic [3:0] PORT_D = 4'd3;
    localparam logic [3:0] PORT_E = 4'd4;
    localparam logic [3:0] PORT_F = 4'd5;
    localparam logic [3:0] PORT_G = 4'd6;
    localparam logic [3:0] PORT_H = 4'd7;
    localparam logic [3:0] PORT_I = 4'd8;

    // scan row for each value of the active-low h latch, 4 means no row
    localparam logic [2:0] ROW_NONE = 3'd4;
    localparam logic [15:0][2:0] ROW_TABLE = {
        3'd4, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0,
        3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0
    };

    // pattern ram access for one cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [3:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // one result item
    typedef struct packed {
        logic [3:0] read_data;
        logic       mode_leds_valid;
        logic [3:0] mode_leds;
        logic       led_row_valid;
        logic [1:0] led_row;
        logic [3:0] led_cols;
        logic       cv_valid;
        logic [5:0] pitch;
        logic       gate;
        logic       accent;
        logic       slide;
    } result_t;

    // ram address from the d, e and f latches
    function automatic logic [ADDR_W-1:0] ram_addr(input logic [3:0] d, input logic [3:0] e,
                                                   input logic [3:0] f);
        logic [1:0] chip;
        chip = e[3:2] - 2'd1;
        return {chip, e[1:0], f, d};
    endfunction

endpackage

// ----- src/synth_board_io_port_decoder_core.sv -----
// board io port decoder: port latches, scan decode, led and cv reports
// a request makes at most one pattern ram access and is registered in stage 1, then in
// the result register; one request per cycle unless the ram clear or output stalls
// reset: latches, pitch and accent cleared; then a ram clearing pass over all 3072
// words, during which no request is taken
// stage 1 lets a new request in while a finished result waits in the result register
module synth_board_io_port_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // wr_nibble[3:0], keys[39:4]
    input  logic [4:0]  s_tuser,   // req_type[0], port[4:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_data, mode_leds, led_row, led_cols, pitch,
                                   // gate, accent, slide
    output logic [2:0]  m_tuser    // mode_leds_valid, led_row_valid, cv_valid
);

    logic        req_type;
    logic [3:0]  port;
    logic [3:0]  wr_nibble;
    logic [35:0] keys;

    logic [3:0] latch_c_reg, latch_d_reg, latch_e_reg, latch_f_reg;
    logic [3:0] latch_g_reg, latch_h_reg, latch_i_reg;
    logic [3:0] latch_c_next, latch_d_next, latch_e_next, latch_f_next;
    logic [3:0] latch_g_next, latch_h_next, latch_i_next;
    logic [5:0] pitch_reg, pitch_next;
    logic       accent_reg, accent_next;

    logic              s1_valid_reg;
    logic              s1_use_ram_reg;
    sbio_pkg::result_t s1_res_reg;
    logic              out_valid_reg;
    sbio_pkg::result_t out_res_reg;

    sbio_pkg::result_t res_next;
    logic              use_ram_next;
    sbio_pkg::ram_req_t ram_req;
    logic [3:0]        ram_rd_data;
    logic              ram_busy;

    logic       s1_adv;
    logic       accept;
    logic [2:0] cur_row;
    logic [2:0] new_row;
    logic       refresh;

    assign req_type  = s_tuser[0];
    assign port      = s_tuser[4:1];
    assign wr_nibble = s_tdata[3:0];
    assign keys      = s_tdata[39:4];

    // handshake
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !ram_busy && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    sbio_pattern_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data),
        .busy    (ram_busy)
    );

    // request decode and latch update
    always_comb
    begin
        latch_c_next = latch_c_reg;
        latch_d_next = latch_d_reg;
        latch_e_next = latch_e_reg;
        latch_f_next = latch_f_reg;
        latch_g_next = latch_g_reg;
        latch_h_next = latch_h_reg;
        latch_i_next = latch_i_reg;
        pitch_next   = pitch_reg;
        accent_next  = accent_reg;
        res_next     = '0;
        use_ram_next = 1'b0;
        refresh      = 1'b0;
        cur_row      = sbio_pkg::ROW_TABLE[latch_h_reg];

        if (req_type == sbio_pkg::REQ_READ)
        begin
            case (port)
                sbio_pkg::PORT_A:
                begin
                    if (cur_row == sbio_pkg::ROW_NONE)
                        res_next.read_data = keys[35:32];
                    else
                        res_next.read_data = keys[{2'b01, cur_row[1:0], 2'b00} +: 4];
                end
                sbio_pkg::PORT_B:
                begin
                    if (cur_row != sbio_pkg::ROW_NONE)
                        res_next.read_data = keys[{2'b00, cur_row[1:0], 2'b00} +: 4];
                end
                sbio_pkg::PORT_C:
                begin
                    use_ram_next = (latch_e_reg[3:2] != 2'd0) && !latch_i_reg[0];
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (port)
                sbio_pkg::PORT_C:
                begin
                    latch_c_next             = wr_nibble;
                    refresh                  = 1'b1;
                    res_next.mode_leds_valid = 1'b1;
                    res_next.mode_leds       = wr_nibble;
                end
                sbio_pkg::PORT_D:
                begin
                    latch_d_next = wr_nibble;
                    refresh      = 1'b1;
                end
                sbio_pkg::PORT_E:
                begin
                    latch_e_next = wr_nibble;
                    refresh      = 1'b1;
                end
                sbio_pkg::PORT_F:
                begin
                    latch_f_next = wr_nibble;
                    refresh      = 1'b1;
                end
                sbio_pkg::PORT_G:
                begin
                    latch_g_next = wr_nibble;
                end
                sbio_pkg::PORT_H:
                begin
                    latch_h_next = wr_nibble;
                end
                sbio_pkg::PORT_I:
                begin
                    // pitch and accent follow a rising edge of the slide bit
                    if (wr_nibble[1] && !latch_i_reg[1])
                    begin
                        pitch_next  = {latch_f_reg[1:0], latch_d_reg};
                        accent_next = latch_e_reg[0];
                    end
                    latch_i_next      = wr_nibble;
                    refresh           = 1'b1;
                    res_next.cv_valid = 1'b1;
                    res_next.pitch    = pitch_next;
                    res_next.gate     = wr_nibble[2];
                    res_next.accent   = accent_next;
                    res_next.slide    = wr_nibble[1];
                end
                default:
                begin
                end
            endcase
        end

        // led matrix row from the updated g and h latches
        new_row = sbio_pkg::ROW_TABLE[latch_h_next];
        if (req_type == sbio_pkg::REQ_WRITE && (port == sbio_pkg::PORT_G ||
            port == sbio_pkg::PORT_H) && new_row != sbio_pkg::ROW_NONE)
        begin
            res_next.led_row_valid = 1'b1;
            res_next.led_row       = new_row[1:0];
            res_next.led_cols      = latch_g_next;
        end

        // ram access: read at the current address, write through at the new one
        ram_req.rd_en   = accept && use_ram_next;
        ram_req.rd_addr = sbio_pkg::ram_addr(latch_d_reg, latch_e_reg, latch_f_reg);
        ram_req.wr_en   = accept && refresh && latch_i_next[0] && (latch_e_next[3:2] != 2'd0);
        ram_req.wr_addr = sbio_pkg::ram_addr(latch_d_next, latch_e_next, latch_f_next);
        ram_req.wr_data = latch_c_next;
    end

    // port latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_c_reg <= 4'd0;
            latch_d_reg <= 4'd0;
            latch_e_reg <= 4'd0;
            latch_f_reg <= 4'd0;
            latch_g_reg <= 4'd0;
            latch_h_reg <= 4'd0;
            latch_i_reg <= 4'd0;
            pitch_reg   <= 6'd0;
            accent_reg  <= 1'b0;
        end
        else if (accept)
        begin
            latch_c_reg <= latch_c_next;
            latch_d_reg <= latch_d_next;
            latch_e_reg <= latch_e_next;
            latch_f_reg <= latch_f_next;
            latch_g_reg <= latch_g_next;
            latch_h_reg <= latch_h_next;
            latch_i_reg <= latch_i_next;
            pitch_reg   <= pitch_next;
            accent_reg  <= accent_next;
        end
    end

    // stage 1 and result register valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg     <= res_next;
            s1_use_ram_reg <= use_ram_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_res_reg <= s1_res_reg;
            if (s1_use_ram_reg)
                out_res_reg.read_data <= ram_rd_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.cv_valid, out_res_reg.led_row_valid,
                       out_res_reg.mode_leds_valid};
    assign m_tdata  = {1'b0, out_res_reg.slide, out_res_reg.accent, out_res_reg.gate,
                       out_res_reg.pitch, out_res_reg.led_cols, out_res_reg.led_row,
                       out_res_reg.mode_leds, out_res_reg.read_data};

`ifndef ASSERT_OFF
    // no request is taken while the ram is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ram_busy |-> !accept)
        else $error("request accepted during ram clear");

    // a result reports at most one kind of update
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("result carries more than one update kind");

    // an update result never carries read data
    a_no_read_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != 3'd0) |-> m_tdata[3:0] == 4'd0)
        else $error("read data on a write result");

    // a ram read is only issued for a taken request
    a_ram_read_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.rd_en |-> accept && !ram_req.wr_en)
        else $error("ram read without request");
`endif

endmodule

// ----- src/sbio_pattern_ram.sv -----
// 3072 x 4 pattern ram with a clearing pass after reset
module sbio_pattern_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  sbio_pkg::ram_req_t req,
    output logic [3:0]        rd_data,
    output logic              busy
);

    logic [3:0]                  mem [sbio_pkg::RAM_DEPTH];
    logic [sbio_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic                        clr_busy_reg;
    logic [3:0]                  rd_data_reg;

    // clear sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == sbio_pkg::ADDR_W'(sbio_pkg::RAM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 4'd0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule
